// File: rtl/core/stp_pkg.sv
// Shared types and codes for the timer pool: request modes, result kinds, the walking token.
`timescale 1ns / 1ps
package stp_pkg;

  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 16;
  localparam int EVENT_W = 8;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_ASSIGN  = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_LOAD    = 2'd3;

  localparam logic [1:0] KIND_ASSIGN = 2'd0;
  localparam logic [1:0] KIND_PREV   = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] prev;
    logic [EVENT_W-1:0] ev;
    logic               cb;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         mode;
    logic [SLOT_W-1:0]  idx;
    logic               per;
    logic               cb;
    logic [EVENT_W-1:0] ev;
    logic [COUNT_W-1:0] tmo;
    logic               pend_valid;
    result_t            pend;
  } token_t;

endpackage

// File: rtl/core/stp_cell.sv
// One timer slot of the pool; it serves the request token as the token passes by.
`timescale 1ns / 1ps
module stp_cell #(
  parameter int CELL_ID = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  stp_pkg::token_t tok_in,
  output stp_pkg::token_t tok_out,
  output logic            emit_req,
  output stp_pkg::result_t emit_res
);
  import stp_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_ID);
  localparam bit ADDRESSABLE = (CELL_ID < (1 << SLOT_W));

  token_t             tok_r;
  logic               in_use_r, in_use_nxt;
  logic               per_r, per_nxt;
  logic               cb_r, cb_nxt;
  logic [EVENT_W-1:0] ev_r, ev_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] rld_r, rld_nxt;
  logic               hit;

  always_comb begin
    tok_out    = tok_r;
    emit_req   = 1'b0;
    emit_res   = tok_r.pend;
    in_use_nxt = in_use_r;
    per_nxt    = per_r;
    cb_nxt     = cb_r;
    ev_nxt     = ev_r;
    rem_nxt    = rem_r;
    rld_nxt    = rld_r;
    hit        = ADDRESSABLE && (tok_r.idx == MY_SLOT);
    if (tok_r.valid) begin
      case (tok_r.mode)
        MODE_TICK: begin
          if (in_use_r && rem_r != '0) begin
            rem_nxt = rem_r - COUNT_W'(1);
            if (rem_r == COUNT_W'(1)) begin
              rem_nxt             = per_r ? rld_r : '0;
              emit_req            = tok_r.pend_valid;
              tok_out.pend_valid  = 1'b1;
              tok_out.pend.kind   = KIND_EXPIRY;
              tok_out.pend.ok     = 1'b0;
              tok_out.pend.slot   = MY_SLOT;
              tok_out.pend.prev   = '0;
              tok_out.pend.ev     = ev_r;
              tok_out.pend.cb     = cb_r;
            end
          end
        end
        MODE_ASSIGN: begin
          if (!in_use_r && !tok_r.pend.ok) begin
            in_use_nxt        = 1'b1;
            per_nxt           = tok_r.per;
            cb_nxt            = tok_r.cb;
            ev_nxt            = tok_r.ev;
            rem_nxt           = '0;
            rld_nxt           = '0;
            tok_out.pend.ok   = 1'b1;
            tok_out.pend.slot = MY_SLOT;
          end
        end
        MODE_RELEASE: begin
          if (hit) begin
            in_use_nxt = 1'b0;
            rem_nxt    = '0;
          end
        end
        MODE_LOAD: begin
          if (hit) begin
            tok_out.pend.prev = rem_r;
            rem_nxt           = tok_r.tmo;
            rld_nxt           = tok_r.tmo;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= '0;
      in_use_r <= 1'b0;
      per_r    <= 1'b0;
      cb_r     <= 1'b0;
      ev_r     <= '0;
      rem_r    <= '0;
      rld_r    <= '0;
    end else if (advance) begin
      tok_r    <= tok_in;
      in_use_r <= in_use_nxt;
      per_r    <= per_nxt;
      cb_r     <= cb_nxt;
      ev_r     <= ev_nxt;
      rem_r    <= rem_nxt;
      rld_r    <= rld_nxt;
    end
  end

endmodule

// File: rtl/core/software_timer_pool.sv
// A request token walks the timer cells one per cycle while the chain is not paused, then a tail stage.
// A new item is taken only after the previous one has finished its walk along the cell chain.
// Each tick expiry is held on the token and sent when the next one is found or the walk ends.
// A stalled output register pauses the whole chain while a result is due, until the result is taken.
// Synchronous active-low reset clears every timer slot and empties the chain.
`timescale 1ns / 1ps
module software_timer_pool #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [stp_pkg::SLOT_W-1:0]     in_timer_index,
  input  logic                           in_periodic,
  input  logic                           in_has_callback,
  input  logic [stp_pkg::EVENT_W-1:0]    in_event_code,
  input  logic [stp_pkg::COUNT_W-1:0]    in_timeout,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_kind,
  output logic                           out_ok,
  output logic [stp_pkg::SLOT_W-1:0]     out_slot,
  output logic [stp_pkg::COUNT_W-1:0]    out_previous_count,
  output logic [stp_pkg::EVENT_W-1:0]    out_expired_event,
  output logic                           out_to_callback,
  output logic                           out_last
);
  import stp_pkg::*;

  token_t                  tok_link [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0]   cell_req;
  result_t                 cell_res [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]   cell_busy;
  token_t                  tail_r;
  logic                    busy_r, busy_nxt;
  logic                    out_valid_r, out_valid_nxt;
  result_t                 out_res_r;
  logic                    out_last_r;
  logic                    in_accept;
  logic                    tail_req;
  logic                    emit_req_any;
  logic                    emit_ok;
  logic                    emit_fire;
  logic                    advance;
  result_t                 emit_res;

  assign in_stall  = busy_r;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    tok_link[0]            = '0;
    tok_link[0].valid      = in_accept;
    tok_link[0].mode       = in_mode;
    tok_link[0].idx        = in_timer_index;
    tok_link[0].per        = in_periodic;
    tok_link[0].cb         = in_has_callback;
    tok_link[0].ev         = in_event_code;
    tok_link[0].tmo        = in_timeout;
    tok_link[0].pend_valid = (in_mode == MODE_ASSIGN) || (in_mode == MODE_LOAD);
    tok_link[0].pend.kind  = (in_mode == MODE_ASSIGN) ? KIND_ASSIGN : KIND_PREV;
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    stp_cell #(
      .CELL_ID(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .tok_in   (tok_link[g]),
      .tok_out  (tok_link[g+1]),
      .emit_req (cell_req[g]),
      .emit_res (cell_res[g])
    );
    assign cell_busy[g] = tok_link[g+1].valid;
  end

  assign tail_req     = tail_r.valid && tail_r.pend_valid;
  assign emit_req_any = (|cell_req) || tail_req;
  assign emit_ok      = !out_valid_r || !out_stall;
  assign emit_fire    = emit_req_any && emit_ok;
  assign advance      = !emit_req_any || emit_ok;

  always_comb begin
    emit_res = tail_req ? tail_r.pend : '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (cell_req[i]) begin
        emit_res = emit_res | cell_res[i];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_accept) begin
      busy_nxt = 1'b1;
    end else if (tail_r.valid && advance) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      tail_r.valid <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        tail_r <= tok_link[NUM_TIMERS];
      end
    end
    if (emit_fire) begin
      out_res_r  <= emit_res;
      out_last_r <= tail_req;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_res_r.kind;
  assign out_ok             = out_res_r.ok;
  assign out_slot           = out_res_r.slot;
  assign out_previous_count = out_res_r.prev;
  assign out_expired_event  = out_res_r.ev;
  assign out_to_callback    = out_res_r.cb;
  assign out_last           = out_last_r;

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cell_busy, tail_r.valid}) <= 1)
    else $error("more than one request token in the chain");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (cell_busy == '0) && !tail_r.valid)
    else $error("item accepted while the chain is occupied");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req_any |-> busy_r)
    else $error("result produced while no item is in flight");

  a_enter_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> cell_busy[0] && busy_r)
    else $error("accepted item did not enter the first cell");

  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r.valid && advance) |=> !busy_r && !tail_r.valid)
    else $error("pool stayed busy after the walk finished");

endmodule

// File: tb/sv/timer_pool_checker.sv
// Checker for the timer pool: tracks every slot, works out the result items and compares them.
`timescale 1ns / 1ps
module timer_pool_checker #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [stp_pkg::SLOT_W-1:0]  in_timer_index,
  input  logic                        in_periodic,
  input  logic                        in_has_callback,
  input  logic [stp_pkg::EVENT_W-1:0] in_event_code,
  input  logic [stp_pkg::COUNT_W-1:0] in_timeout,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [1:0]                  out_kind,
  input  logic                        out_ok,
  input  logic [stp_pkg::SLOT_W-1:0]  out_slot,
  input  logic [stp_pkg::COUNT_W-1:0] out_previous_count,
  input  logic [stp_pkg::EVENT_W-1:0] out_expired_event,
  input  logic                        out_to_callback,
  input  logic                        out_last,
  output int                          mismatch_count,
  output int                          answers_due
);
  import stp_pkg::*;

  localparam int REPORT_CAP = 200;

  typedef struct packed {
    logic [1:0]         kind;
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] prev;
    logic [EVENT_W-1:0] ev;
    logic               cb;
    logic               last;
  } timer_answer_t;

  logic               slot_used     [NUM_TIMERS];
  logic               slot_periodic [NUM_TIMERS];
  logic               slot_callback [NUM_TIMERS];
  logic [EVENT_W-1:0] slot_event    [NUM_TIMERS];
  logic [COUNT_W-1:0] slot_count    [NUM_TIMERS];
  logic [COUNT_W-1:0] slot_reload   [NUM_TIMERS];

  timer_answer_t answer_queue[$];
  timer_answer_t oldest;

  function automatic timer_answer_t make_answer(input logic [1:0] kind, input logic ok,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [COUNT_W-1:0] prev,
                                                input logic [EVENT_W-1:0] ev,
                                                input logic cb);
    timer_answer_t a;
    a.kind = kind;
    a.ok   = ok;
    a.slot = slot;
    a.prev = prev;
    a.ev   = ev;
    a.cb   = cb;
    a.last = 1'b0;
    return a;
  endfunction

  task automatic apply_request(input logic [1:0] mode, input logic [SLOT_W-1:0] idx,
                               input logic per, input logic cb,
                               input logic [EVENT_W-1:0] ev,
                               input logic [COUNT_W-1:0] tmo);
    timer_answer_t fresh[$];
    timer_answer_t a;
    logic          granted;
    logic [COUNT_W-1:0] prev;
    int            i;
    int            k;
    granted = 1'b0;
    prev    = '0;
    case (mode)
      MODE_TICK: begin
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (slot_used[i] && slot_count[i] != 0) begin
            slot_count[i] = slot_count[i] - 1'b1;
            if (slot_count[i] == 0) begin
              if (slot_periodic[i]) slot_count[i] = slot_reload[i];
              fresh.push_back(make_answer(KIND_EXPIRY, 1'b0, SLOT_W'(i), '0,
                                          slot_event[i], slot_callback[i]));
            end
          end
        end
      end
      MODE_ASSIGN: begin
        for (i = 0; i < NUM_TIMERS && !granted; i++) begin
          if (!slot_used[i]) begin
            slot_used[i]     = 1'b1;
            slot_periodic[i] = per;
            slot_callback[i] = cb;
            slot_event[i]    = ev;
            slot_count[i]    = '0;
            slot_reload[i]   = '0;
            granted          = 1'b1;
            fresh.push_back(make_answer(KIND_ASSIGN, 1'b1, SLOT_W'(i), '0, '0, 1'b0));
          end
        end
        if (!granted) fresh.push_back(make_answer(KIND_ASSIGN, 1'b0, '0, '0, '0, 1'b0));
      end
      MODE_RELEASE: begin
        if (idx < NUM_TIMERS) begin
          slot_used[idx]  = 1'b0;
          slot_count[idx] = '0;
        end
      end
      default: begin
        if (idx < NUM_TIMERS) begin
          prev             = slot_count[idx];
          slot_count[idx]  = tmo;
          slot_reload[idx] = tmo;
        end
        fresh.push_back(make_answer(KIND_PREV, 1'b0, '0, prev, '0, 1'b0));
      end
    endcase
    for (k = 0; k < fresh.size(); k++) begin
      a = fresh[k];
      a.last = (k == fresh.size() - 1);
      answer_queue.push_back(a);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_CAP) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h (kind %0d, slot %0d)",
                                name, got, want, oldest.kind, oldest.slot));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        slot_used[i]     = 1'b0;
        slot_periodic[i] = 1'b0;
        slot_callback[i] = 1'b0;
        slot_event[i]    = '0;
        slot_count[i]    = '0;
        slot_reload[i]   = '0;
      end
      answer_queue.delete();
      answers_due <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(in_mode, in_timer_index, in_periodic, in_has_callback,
                      in_event_code, in_timeout);
      end
      if (out_valid && !out_stall) begin
        if (answer_queue.size() == 0) begin
          report_mismatch($sformatf("result item with nothing due: kind %0d slot %0d",
                                    out_kind, out_slot));
        end else begin
          oldest = answer_queue.pop_front();
          check_field("kind", out_kind, oldest.kind);
          check_field("ok", out_ok, oldest.ok);
          check_field("slot", out_slot, oldest.slot);
          check_field("previous_count", out_previous_count, oldest.prev);
          check_field("expired_event", out_expired_event, oldest.ev);
          check_field("to_callback", out_to_callback, oldest.cb);
          check_field("last", out_last, oldest.last);
        end
      end
      answers_due <= answer_queue.size();
    end
  end

endmodule

// File: tb/sv/tb_software_timer_pool.sv
// Top of the timer pool testbench: clock, reset, request items, result stalls and the verdict.
`timescale 1ns / 1ps
module tb_software_timer_pool;
  import stp_pkg::*;

  localparam int NUM_TIMERS   = 16;
  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode         = MODE_TICK;
  logic [SLOT_W-1:0]  in_timer_index  = '0;
  logic               in_periodic     = 1'b0;
  logic               in_has_callback = 1'b0;
  logic [EVENT_W-1:0] in_event_code   = '0;
  logic [COUNT_W-1:0] in_timeout      = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [1:0]         out_kind;
  logic               out_ok;
  logic [SLOT_W-1:0]  out_slot;
  logic [COUNT_W-1:0] out_previous_count;
  logic [EVENT_W-1:0] out_expired_event;
  logic               out_to_callback;
  logic               out_last;

  int mismatch_count;
  int answers_due;
  int cycles      = 0;
  int stall_left  = 0;
  int stall_style = 0;

  software_timer_pool #(.NUM_TIMERS(NUM_TIMERS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_timer_index(in_timer_index), .in_periodic(in_periodic),
    .in_has_callback(in_has_callback), .in_event_code(in_event_code),
    .in_timeout(in_timeout),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind), .out_ok(out_ok),
    .out_slot(out_slot), .out_previous_count(out_previous_count),
    .out_expired_event(out_expired_event), .out_to_callback(out_to_callback),
    .out_last(out_last)
  );

  timer_pool_checker #(.NUM_TIMERS(NUM_TIMERS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_timer_index(in_timer_index), .in_periodic(in_periodic),
    .in_has_callback(in_has_callback), .in_event_code(in_event_code),
    .in_timeout(in_timeout),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind), .out_ok(out_ok),
    .out_slot(out_slot), .out_previous_count(out_previous_count),
    .out_expired_event(out_expired_event), .out_to_callback(out_to_callback),
    .out_last(out_last),
    .mismatch_count(mismatch_count), .answers_due(answers_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 16) < 6;
    endcase
  end

  task automatic send_request(input logic [1:0] mode, input logic [SLOT_W-1:0] idx,
                              input logic per, input logic cb,
                              input logic [EVENT_W-1:0] ev,
                              input logic [COUNT_W-1:0] tmo);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_timer_index  <= idx;
    in_periodic     <= per;
    in_has_callback <= cb;
    in_event_code   <= ev;
    in_timeout      <= tmo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int gap);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic send_random_request();
    int                 pick;
    int                 shape;
    logic [1:0]         mode;
    logic [COUNT_W-1:0] tmo;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    if (pick < 45) mode = MODE_TICK;
    else if (pick < 60) mode = MODE_ASSIGN;
    else if (pick < 70) mode = MODE_RELEASE;
    else mode = MODE_LOAD;
    if (shape == 0) tmo = '0;
    else if (shape == 1) tmo = '1;
    else if (shape == 2) tmo = COUNT_W'($urandom);
    else tmo = COUNT_W'($urandom_range(1, 6));
    send_request(mode, SLOT_W'($urandom_range(0, NUM_TIMERS - 1)), 1'($urandom),
                 1'($urandom), EVENT_W'($urandom), tmo);
  endtask

  initial begin
    int s;
    int sent;
    int burst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_request(MODE_TICK, '0, 1'b0, 1'b0, '0, '0);
    send_request(MODE_LOAD, 4'd15, 1'b0, 1'b0, '0, 16'hFFFF);
    for (s = 0; s < NUM_TIMERS; s++) begin
      send_request(MODE_ASSIGN, '0, s[0], s[1], EVENT_W'(s * 17), '0);
    end
    send_request(MODE_ASSIGN, '0, 1'b1, 1'b1, 8'hFF, '0);
    send_request(MODE_LOAD, 4'd0, 1'b0, 1'b0, '0, 16'd1);
    send_request(MODE_LOAD, 4'd1, 1'b0, 1'b0, '0, 16'd1);
    send_request(MODE_LOAD, 4'd14, 1'b0, 1'b0, '0, 16'd2);
    send_request(MODE_TICK, '0, 1'b0, 1'b0, '0, '0);
    send_request(MODE_TICK, '0, 1'b0, 1'b0, '0, '0);
    send_request(MODE_LOAD, 4'd1, 1'b0, 1'b0, '0, 16'd0);
    send_request(MODE_RELEASE, 4'd0, 1'b0, 1'b0, '0, '0);
    send_request(MODE_ASSIGN, '0, 1'b1, 1'b0, 8'h5A, '0);
    send_request(MODE_LOAD, 4'd2, 1'b0, 1'b0, '0, 16'hFFFF);
    pause_sender($urandom_range(1, 40));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_random_request();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
    repeat (3 * (NUM_TIMERS + 2)) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/stp_pkg.sv
rtl/core/stp_cell.sv
rtl/core/software_timer_pool.sv
tb/sv/timer_pool_checker.sv
tb/sv/tb_software_timer_pool.sv
